[rtl/dlwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlwc_pkg
// Shared types and constants of the display-list window clipper.
// ----------------------------------------------------------------------------
package dlwc_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 16;
    localparam int COLOR_W     = 32;
    localparam int THICK_W     = 23;
    localparam int SIDE_W      = COLOR_W + THICK_W;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;

    typedef enum logic [1:0] {
        KIND_LINE   = 2'd0,
        KIND_RECT   = 2'd1,
        KIND_CIRCLE = 2'd2,
        KIND_OTHER  = 2'd3
    } kind_t;

    // per-record control carried down the clip pipeline
    typedef struct packed {
        logic  act;     // line still being clipped
        logic  keep;
        logic  sw;      // endpoints held in swapped order
        logic  last;
        kind_t kind;
        logic  cut_l;   // cut at low edge of current axis
        logic  cut_r;   // cut at high edge of current axis
        logic  neg_l;   // sign of low-edge intercept offset
        logic  neg_r;   // sign of high-edge intercept offset
    } ctl_t;

endpackage

[rtl/dlwc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlwc_front
// Accepts records, classifies them against the window, orders line
// endpoints by x and prepares the x-edge cuts for the back end.
// ----------------------------------------------------------------------------
module dlwc_front #(
    parameter int CW = dlwc_pkg::COORD_WIDTH
) (
    input  logic signed [CW-1:0]             win_x_low,
    input  logic signed [CW-1:0]             win_y_low,
    input  logic signed [CW-1:0]             win_x_high,
    input  logic signed [CW-1:0]             win_y_high,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [1:0]                       kind,
    input  logic signed [CW-1:0]             x_start,
    input  logic signed [CW-1:0]             y_start,
    input  logic signed [CW-1:0]             x_end,
    input  logic signed [CW-1:0]             y_end,
    input  logic [dlwc_pkg::SIDE_W-1:0]      side,
    input  logic                             last,
    input  logic                             full,
    output logic                             push,
    output logic [$bits(dlwc_pkg::ctl_t)+8*CW+12+dlwc_pkg::SIDE_W-1:0] word
);

    localparam int E = CW + 2;
    localparam int Q = CW + 1;

    logic signed [E-1:0] xl, yl, xh, yh, xs, ys, xe, ye;
    logic signed [E-1:0] ax, ay, bx, by, dd, sv, nl, nr, svm, nlm, nrm;
    logic signed [E-1:0] cxp, cxm, cyp, cym;
    logic                win_ok, swp, rej, rect_ok, circ_ok, keep;
    dlwc_pkg::ctl_t      ctl;

    assign xl = E'(win_x_low);
    assign yl = E'(win_y_low);
    assign xh = E'(win_x_high);
    assign yh = E'(win_y_high);
    assign xs = E'(x_start);
    assign ys = E'(y_start);
    assign xe = E'(x_end);
    assign ye = E'(y_end);

    assign win_ok = (xl < xh) && (yl < yh);

    assign swp = (kind == dlwc_pkg::KIND_LINE) && (xs > xe);
    assign ax  = swp ? xe : xs;
    assign ay  = swp ? ye : ys;
    assign bx  = swp ? xs : xe;
    assign by  = swp ? ys : ye;

    assign rej = (bx < xl) || (ax > xh) ||
                 ((ay < by) ? ((by < yl) || (ay > yh)) : ((ay < yl) || (by > yh)));

    assign rect_ok = (xs >= xl) && (xs <= xh) && (ys >= yl) && (ys <= yh) &&
                     (xe >= xl) && (xe <= xh) && (ye >= yl) && (ye <= yh);

    // circle: radius travels in x_end
    assign cxp = xs + xe;
    assign cxm = xs - xe;
    assign cyp = ys + xe;
    assign cym = ys - xe;
    assign circ_ok = (cxp >= xl) && (cxp <= xh) && (cxm >= xl) && (cxm <= xh) &&
                     (xs >= xl) && (xs <= xh) && (ys >= yl) && (ys <= yh) &&
                     (cyp >= yl) && (cyp <= yh) && (cym >= yl) && (cym <= yh);

    always_comb
    begin
        case (kind)
            dlwc_pkg::KIND_LINE:   keep = win_ok && !rej;
            dlwc_pkg::KIND_RECT:   keep = win_ok && rect_ok;
            dlwc_pkg::KIND_CIRCLE: keep = win_ok && circ_ok;
            dlwc_pkg::KIND_OTHER:  keep = 1'b0;
            default:               keep = 1'b0;
        endcase
    end

    assign dd  = bx - ax;
    assign sv  = by - ay;
    assign nl  = xl - ax;
    assign nr  = xh - bx;
    assign svm = sv[E-1] ? -sv : sv;
    assign nlm = nl[E-1] ? -nl : nl;
    assign nrm = nr[E-1] ? -nr : nr;

    always_comb
    begin
        ctl.act   = (kind == dlwc_pkg::KIND_LINE) && keep;
        ctl.keep  = keep;
        ctl.sw    = swp;
        ctl.last  = last;
        ctl.kind  = dlwc_pkg::kind_t'(kind);
        ctl.cut_l = ctl.act && (dd != '0) && (ax < xl);
        ctl.cut_r = ctl.act && (dd != '0) && (bx > xh);
        ctl.neg_l = sv[E-1] ^ nl[E-1];
        ctl.neg_r = sv[E-1] ^ nr[E-1];
    end

    assign word = {ctl, ax, ay, bx, by, dd[Q-1:0], svm[Q-1:0], nlm[Q-1:0], nrm[Q-1:0],
                   side};

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

endmodule

[rtl/dlwc_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlwc_fifo
// Two-word queue between the classifier and the clip pipeline.
// ----------------------------------------------------------------------------
module dlwc_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         not_empty
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0]  mem [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata     = mem[rd_ptr_reg];
    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("pop from empty queue");
`endif

endmodule

[rtl/dlwc_cut.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlwc_cut
// Cuts a segment at the low and high edge of one axis: one multiply stage,
// then a restoring divider retiring one quotient bit per stage.
// ----------------------------------------------------------------------------
module dlwc_cut #(
    parameter int CW = dlwc_pkg::COORD_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  dlwc_pkg::ctl_t              in_ctl,
    input  logic signed [CW+1:0]        in_ua,
    input  logic signed [CW+1:0]        in_va,
    input  logic signed [CW+1:0]        in_ub,
    input  logic signed [CW+1:0]        in_vb,
    input  logic [CW:0]                 in_d,
    input  logic [CW:0]                 in_sv,
    input  logic [CW:0]                 in_nl,
    input  logic [CW:0]                 in_nr,
    input  logic [dlwc_pkg::SIDE_W-1:0] in_side,
    input  logic signed [CW+1:0]        lo,
    input  logic signed [CW+1:0]        hi,
    output logic                        out_valid,
    output dlwc_pkg::ctl_t              out_ctl,
    output logic signed [CW+1:0]        out_ua,
    output logic signed [CW+1:0]        out_va,
    output logic signed [CW+1:0]        out_ub,
    output logic signed [CW+1:0]        out_vb,
    output logic [dlwc_pkg::SIDE_W-1:0] out_side
);

    localparam int E  = CW + 2;
    localparam int Q  = CW + 1;
    localparam int PW = $bits(dlwc_pkg::ctl_t) + 4*E + dlwc_pkg::SIDE_W;

    logic          v_reg   [0:Q];
    logic [PW-1:0] pay_reg [0:Q];
    logic [Q-1:0]  d_reg   [0:Q];
    logic [Q-1:0]  rl_reg  [0:Q];
    logic [Q-1:0]  ll_reg  [0:Q];
    logic [Q-1:0]  rr_reg  [0:Q];
    logic [Q-1:0]  lr_reg  [0:Q];

    logic [2*Q-1:0] pl, pr;

    assign pl = (2*Q)'(in_sv) * (2*Q)'(in_nl);
    assign pr = (2*Q)'(in_sv) * (2*Q)'(in_nr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0] <= {in_ctl, in_ua, in_va, in_ub, in_vb, in_side};
            d_reg[0]   <= in_d;
            rl_reg[0]  <= pl[2*Q-1:Q];
            ll_reg[0]  <= pl[Q-1:0];
            rr_reg[0]  <= pr[2*Q-1:Q];
            lr_reg[0]  <= pr[Q-1:0];
        end
    end

    // the low half of each dividend shifts out as quotient bits shift in
    for (genvar k = 0; k < Q; k++)
    begin : g_div
        logic [Q:0] tl, tr;
        logic       gl, gr;

        assign tl = {rl_reg[k], ll_reg[k][Q-1]};
        assign tr = {rr_reg[k], lr_reg[k][Q-1]};
        assign gl = (tl >= {1'b0, d_reg[k]});
        assign gr = (tr >= {1'b0, d_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pay_reg[k+1] <= pay_reg[k];
                d_reg[k+1]   <= d_reg[k];
                rl_reg[k+1]  <= gl ? Q'(tl - {1'b0, d_reg[k]}) : tl[Q-1:0];
                ll_reg[k+1]  <= {ll_reg[k][Q-2:0], gl};
                rr_reg[k+1]  <= gr ? Q'(tr - {1'b0, d_reg[k]}) : tr[Q-1:0];
                lr_reg[k+1]  <= {lr_reg[k][Q-2:0], gr};
            end
        end
    end

    dlwc_pkg::ctl_t      c;
    logic signed [E-1:0] ua, va, ub, vb, qle, qre;

    assign {c, ua, va, ub, vb, out_side} = pay_reg[Q];
    assign qle = E'(ll_reg[Q]);
    assign qre = E'(lr_reg[Q]);

    assign out_valid = v_reg[Q];
    assign out_ctl   = c;
    assign out_ua    = c.cut_l ? lo : ua;
    assign out_va    = c.cut_l ? va + (c.neg_l ? -qle : qle) : va;
    assign out_ub    = c.cut_r ? hi : ub;
    assign out_vb    = c.cut_r ? vb + (c.neg_r ? -qre : qre) : vb;

endmodule

[rtl/dlwc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlwc_back
// Clip pipeline: x-edge cut, y recheck and reorder, y-edge cut, then the
// output register with endpoint order restored.
// ----------------------------------------------------------------------------
module dlwc_back #(
    parameter int CW = dlwc_pkg::COORD_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  logic [$bits(dlwc_pkg::ctl_t)+8*CW+12+dlwc_pkg::SIDE_W-1:0] q_word,
    output logic                  pop,
    input  logic signed [CW-1:0]  win_x_low,
    input  logic signed [CW-1:0]  win_y_low,
    input  logic signed [CW-1:0]  win_x_high,
    input  logic signed [CW-1:0]  win_y_high,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((1+4*CW+dlwc_pkg::SIDE_W+7)/8)*8-1:0] m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int E   = CW + 2;
    localparam int Q   = CW + 1;
    localparam int ODW = ((1 + 4*CW + dlwc_pkg::SIDE_W + 7) / 8) * 8;

    logic signed [E-1:0] xl, yl, xh, yh;
    logic                en;

    assign xl = E'(win_x_low);
    assign yl = E'(win_y_low);
    assign xh = E'(win_x_high);
    assign yh = E'(win_y_high);

    logic                        ov_reg;
    assign en  = !ov_reg || m_tready;
    assign pop = en && q_valid;

    dlwc_pkg::ctl_t              f_ctl;
    logic signed [E-1:0]         f_ua, f_va, f_ub, f_vb;
    logic [Q-1:0]                f_d, f_sv, f_nl, f_nr;
    logic [dlwc_pkg::SIDE_W-1:0] f_side;

    assign {f_ctl, f_ua, f_va, f_ub, f_vb, f_d, f_sv, f_nl, f_nr, f_side} = q_word;

    logic                        x_valid;
    dlwc_pkg::ctl_t              x_ctl;
    logic signed [E-1:0]         xa, ya, xb, yb;
    logic [dlwc_pkg::SIDE_W-1:0] x_side;

    dlwc_cut #(.CW(CW)) u_cut_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (q_valid),
        .in_ctl   (f_ctl),
        .in_ua    (f_ua),
        .in_va    (f_va),
        .in_ub    (f_ub),
        .in_vb    (f_vb),
        .in_d     (f_d),
        .in_sv    (f_sv),
        .in_nl    (f_nl),
        .in_nr    (f_nr),
        .in_side  (f_side),
        .lo       (xl),
        .hi       (xh),
        .out_valid(x_valid),
        .out_ctl  (x_ctl),
        .out_ua   (xa),
        .out_va   (ya),
        .out_ub   (xb),
        .out_vb   (yb),
        .out_side (x_side)
    );

    // y recheck, reorder so y rises, prepare y-edge cuts
    logic                        up, rej2, swap;
    logic signed [E-1:0]         cx, cy, ex, ey, dd2, sv2, nl2, nr2, svm2, nlm2, nrm2;
    dlwc_pkg::ctl_t              b_ctl_next, b_ctl_reg;
    logic                        b_v_reg;
    logic signed [E-1:0]         b_ua_reg, b_va_reg, b_ub_reg, b_vb_reg;
    logic [Q-1:0]                b_d_reg, b_sv_reg, b_nl_reg, b_nr_reg;
    logic [dlwc_pkg::SIDE_W-1:0] b_side_reg;

    assign up   = (ya < yb);
    assign rej2 = up ? ((yb < yl) || (ya > yh)) : ((ya < yl) || (yb > yh));
    assign swap = x_ctl.act && !rej2 && !up;
    assign cx   = swap ? xb : xa;
    assign cy   = swap ? yb : ya;
    assign ex   = swap ? xa : xb;
    assign ey   = swap ? ya : yb;
    assign dd2  = ey - cy;
    assign sv2  = ex - cx;
    assign nl2  = yl - cy;
    assign nr2  = yh - ey;
    assign svm2 = sv2[E-1] ? -sv2 : sv2;
    assign nlm2 = nl2[E-1] ? -nl2 : nl2;
    assign nrm2 = nr2[E-1] ? -nr2 : nr2;

    always_comb
    begin
        b_ctl_next       = x_ctl;
        b_ctl_next.act   = x_ctl.act && !rej2;
        b_ctl_next.keep  = x_ctl.keep && !(x_ctl.act && rej2);
        b_ctl_next.sw    = x_ctl.sw ^ swap;
        b_ctl_next.cut_l = b_ctl_next.act && (dd2 != '0) && (cy < yl);
        b_ctl_next.cut_r = b_ctl_next.act && (dd2 != '0) && (ey > yh);
        b_ctl_next.neg_l = sv2[E-1] ^ nl2[E-1];
        b_ctl_next.neg_r = sv2[E-1] ^ nr2[E-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg <= x_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ctl_reg  <= b_ctl_next;
            b_ua_reg   <= cy;
            b_va_reg   <= cx;
            b_ub_reg   <= ey;
            b_vb_reg   <= ex;
            b_d_reg    <= dd2[Q-1:0];
            b_sv_reg   <= svm2[Q-1:0];
            b_nl_reg   <= nlm2[Q-1:0];
            b_nr_reg   <= nrm2[Q-1:0];
            b_side_reg <= x_side;
        end
    end

    logic                        y_valid;
    dlwc_pkg::ctl_t              y_ctl;
    logic signed [E-1:0]         fya, fxa, fyb, fxb;
    logic [dlwc_pkg::SIDE_W-1:0] y_side;

    dlwc_cut #(.CW(CW)) u_cut_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (b_v_reg),
        .in_ctl   (b_ctl_reg),
        .in_ua    (b_ua_reg),
        .in_va    (b_va_reg),
        .in_ub    (b_ub_reg),
        .in_vb    (b_vb_reg),
        .in_d     (b_d_reg),
        .in_sv    (b_sv_reg),
        .in_nl    (b_nl_reg),
        .in_nr    (b_nr_reg),
        .in_side  (b_side_reg),
        .lo       (yl),
        .hi       (yh),
        .out_valid(y_valid),
        .out_ctl  (y_ctl),
        .out_ua   (fya),
        .out_va   (fxa),
        .out_ub   (fyb),
        .out_vb   (fxb),
        .out_side (y_side)
    );

    logic                        o_keep_reg, o_keep_next, o_last_reg;
    dlwc_pkg::kind_t             o_kind_reg, o_kind_next;
    logic [CW-1:0]               o_xs_reg, o_ys_reg, o_xe_reg, o_ye_reg;
    logic [CW-1:0]               o_xs_next, o_ys_next, o_xe_next, o_ye_next;
    logic [dlwc_pkg::SIDE_W-1:0] o_side_reg, o_side_next;

    always_comb
    begin
        o_keep_next = y_ctl.keep;
        o_kind_next = dlwc_pkg::KIND_LINE;
        o_xs_next   = '0;
        o_ys_next   = '0;
        o_xe_next   = '0;
        o_ye_next   = '0;
        o_side_next = '0;
        if (y_ctl.keep)
        begin
            o_kind_next = y_ctl.kind;
            o_side_next = y_side;
            if (y_ctl.sw)
            begin
                o_xs_next = fxb[CW-1:0];
                o_ys_next = fyb[CW-1:0];
                o_xe_next = fxa[CW-1:0];
                o_ye_next = fya[CW-1:0];
            end
            else
            begin
                o_xs_next = fxa[CW-1:0];
                o_ys_next = fya[CW-1:0];
                o_xe_next = fxb[CW-1:0];
                o_ye_next = fyb[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= y_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_keep_reg <= o_keep_next;
            o_kind_reg <= o_kind_next;
            o_xs_reg   <= o_xs_next;
            o_ys_reg   <= o_ys_next;
            o_xe_reg   <= o_xe_next;
            o_ye_reg   <= o_ye_next;
            o_side_reg <= o_side_next;
            o_last_reg <= y_ctl.last;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = ODW'({o_side_reg, o_ye_reg, o_xe_reg, o_ys_reg, o_xs_reg, o_keep_reg});
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

`ifndef SYNTHESIS
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !o_keep_reg) |-> (o_xs_reg == '0 && o_ys_reg == '0 &&
        o_xe_reg == '0 && o_ye_reg == '0 && o_side_reg == '0 &&
        o_kind_reg == dlwc_pkg::KIND_LINE))
        else $error("dropped record carries payload");
    a_other_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && o_keep_reg) |-> o_kind_reg != dlwc_pkg::KIND_OTHER)
        else $error("unknown shape kept");
`endif

endmodule

[rtl/display_list_window_clipper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_list_window_clipper
// Clips display-list records (line, rectangle, circle) to a window.
// ----------------------------------------------------------------------------
// Usage:
//   Records enter on the s_ stream: tuser holds the kind, tlast the end of
//   the list marker, tdata the coordinates, colour and thickness. Each word
//   yields exactly one word on the m_ stream with a keep flag; dropped
//   records carry zeros except tlast.
//   The window lives in four APB registers (left, bottom, right, top at
//   byte addresses 0, 4, 8, 12); write them only while the block is empty.
//   Throughput: one word per cycle while m_tready is high. The two
//   pipelined restoring dividers of the x and y edge cuts, one quotient
//   bit per stage, set the depth of the pipeline.
//   A two-word queue sits between classifier and clip pipeline; when
//   m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready drops once the queue is full.
//   Reset empties the pipeline and sets the window to 0..1.0 on both axes.
// ----------------------------------------------------------------------------
module display_list_window_clipper #(
    parameter int COORD_WIDTH = dlwc_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = dlwc_pkg::FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dlwc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dlwc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dlwc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // x_start, y_start, x_end, y_end, color_word, thickness, zero pad
    input  logic [((4*COORD_WIDTH+dlwc_pkg::SIDE_W+7)/8)*8-1:0]   s_tdata,
    // kind
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // keep, out_x_start, out_y_start, out_x_end, out_y_end, out_color,
    // out_thickness, zero pad
    output logic [((1+4*COORD_WIDTH+dlwc_pkg::SIDE_W+7)/8)*8-1:0] m_tdata,
    // out_kind
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);

    localparam int CW = COORD_WIDTH;
    localparam int W  = $bits(dlwc_pkg::ctl_t) + 8*CW + 12 + dlwc_pkg::SIDE_W;

    localparam logic [1:0] REG_X_LOW  = 2'd0;
    localparam logic [1:0] REG_Y_LOW  = 2'd1;
    localparam logic [1:0] REG_X_HIGH = 2'd2;
    localparam logic [1:0] REG_Y_HIGH = 2'd3;

    localparam logic [CW-1:0] WIN_HI_RST = CW'(64'd1 << FRAC_BITS);

    logic [CW-1:0] win_x_low_reg, win_y_low_reg, win_x_high_reg, win_y_high_reg;
    logic          wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_low_reg  <= '0;
            win_y_low_reg  <= '0;
            win_x_high_reg <= WIN_HI_RST;
            win_y_high_reg <= WIN_HI_RST;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_X_LOW:  win_x_low_reg  <= pwdata[CW-1:0];
                REG_Y_LOW:  win_y_low_reg  <= pwdata[CW-1:0];
                REG_X_HIGH: win_x_high_reg <= pwdata[CW-1:0];
                REG_Y_HIGH: win_y_high_reg <= pwdata[CW-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_X_LOW:  prdata = dlwc_pkg::APB_DATA_W'(win_x_low_reg);
            REG_Y_LOW:  prdata = dlwc_pkg::APB_DATA_W'(win_y_low_reg);
            REG_X_HIGH: prdata = dlwc_pkg::APB_DATA_W'(win_x_high_reg);
            REG_Y_HIGH: prdata = dlwc_pkg::APB_DATA_W'(win_y_high_reg);
            default:    prdata = '0;
        endcase
    end

    logic         full, not_empty, push, pop;
    logic [W-1:0] f_word, q_word;

    dlwc_front #(.CW(CW)) u_front (
        .win_x_low (win_x_low_reg),
        .win_y_low (win_y_low_reg),
        .win_x_high(win_x_high_reg),
        .win_y_high(win_y_high_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .kind      (s_tuser),
        .x_start   (s_tdata[CW-1:0]),
        .y_start   (s_tdata[2*CW-1:CW]),
        .x_end     (s_tdata[3*CW-1:2*CW]),
        .y_end     (s_tdata[4*CW-1:3*CW]),
        .side      (s_tdata[4*CW+dlwc_pkg::SIDE_W-1:4*CW]),
        .last      (s_tlast),
        .full      (full),
        .push      (push),
        .word      (f_word)
    );

    dlwc_fifo #(.W(W)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (f_word),
        .pop      (pop),
        .rdata    (q_word),
        .full     (full),
        .not_empty(not_empty)
    );

    dlwc_back #(.CW(CW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_word    (q_word),
        .pop       (pop),
        .win_x_low (win_x_low_reg),
        .win_y_low (win_y_low_reg),
        .win_x_high(win_x_high_reg),
        .win_y_high(win_y_high_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
